// ===== rtl/core/mkd_pkg.sv =====
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types, constants and the letter table of the Morse key decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

  // Field widths
  localparam int unsigned CountWidth   = 16;
  localparam int unsigned LengthWidth  = 4;
  localparam int unsigned PatternWidth = 8;
  localparam int unsigned LetterWidth  = 5;
  localparam int unsigned CfgIdxWidth  = 2;

  // Symbol length cap default
  localparam int unsigned MaxElementsDef = 8;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgDashThreshold = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgLetterGap     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgWordGap       = 2'd2;

  // Configuration reset values
  localparam logic [CountWidth-1:0] DashThresholdRst = 16'd300;
  localparam logic [CountWidth-1:0] LetterGapRst     = 16'd700;
  localparam logic [CountWidth-1:0] WordGapRst       = 16'd1500;

  // Letter codes
  localparam int unsigned            LetterCount   = 26;
  localparam logic [LetterWidth-1:0] UnknownLetter = 5'd26;
  localparam logic [LengthWidth-1:0] MaxLookupLen  = 4'd4;

  // Element count and pattern (bit i = element i, 1 = dash) for A to Z
  localparam logic [LengthWidth-1:0] CodeLen [LetterCount] = '{
    4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2, 4'd4, 4'd3, 4'd4, 4'd2,
    4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd1, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4
  };
  localparam logic [PatternWidth-1:0] CodeBits [LetterCount] = '{
    8'd2, 8'd1, 8'd5, 8'd1, 8'd0, 8'd4, 8'd3, 8'd0, 8'd0, 8'd14, 8'd5, 8'd2, 8'd3,
    8'd1, 8'd7, 8'd6, 8'd11, 8'd2, 8'd0, 8'd1, 8'd4, 8'd8, 8'd6, 8'd9, 8'd13, 8'd3
  };

  // Event kinds
  typedef enum logic [1:0] {
    EVT_DOT    = 2'd0,
    EVT_DASH   = 2'd1,
    EVT_LETTER = 2'd2,
    EVT_SPACE  = 2'd3
  } mkd_event_e;

  // Configuration registers as seen by the timing logic
  typedef struct packed {
    logic [CountWidth-1:0] dash_threshold;
    logic [CountWidth-1:0] letter_gap;
    logic [CountWidth-1:0] word_gap;
  } mkd_cfg_t;

  // One result
  typedef struct packed {
    mkd_event_e                kind;
    logic [LetterWidth-1:0]    letter;
    logic [LengthWidth-1:0]    length;
    logic [PatternWidth-1:0]   pattern;
  } mkd_event_t;

endpackage

// ===== rtl/core/mkd_if.sv =====
// ----------------------------------------------------------------------------
// mkd_if
// Request channels of the Morse key decoder: key samples, events, config.
// ----------------------------------------------------------------------------

// Key sample channel
interface mkd_key_if
  import mkd_pkg::*;
();
  logic valid;
  logic ready;
  logic key_down;

  modport source (output valid, output key_down, input ready);
  modport sink   (input valid, input key_down, output ready);
endinterface

// Event channel
interface mkd_evt_if
  import mkd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [1:0]              event_kind;
  logic [LetterWidth-1:0]  letter_code;
  logic [LengthWidth-1:0]  symbol_length;
  logic [PatternWidth-1:0] symbol_pattern;

  modport source (output valid, output event_kind, output letter_code,
                  output symbol_length, output symbol_pattern, input ready);
  modport sink   (input valid, input event_kind, input letter_code,
                  input symbol_length, input symbol_pattern, output ready);
endinterface

// Configuration write channel
interface mkd_cfg_if
  import mkd_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CfgIdxWidth-1:0] index;
  logic [CountWidth-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/morse_key_decoder_core.sv =====
// ----------------------------------------------------------------------------
// morse_key_decoder_core
// Decodes a sampled Morse key into dot, dash, letter and space events.
// ----------------------------------------------------------------------------
// The block takes one key sample per cycle, back to back, unless the key
// channel stalls, and gives at most one event per sample. A sample accepted
// at a clock edge is held in the sample register. The timing update for it
// runs once the event register can move on: it holds the press and gap
// counters and the pending symbol, and it does the A to Z lookup. The event
// is loaded into the event register at the end of that update and is offered
// from there. A new sample is accepted whenever the sample register is empty
// or the event register can move on. The key channel stalls only when both
// registers are full and the waiting event is not taken. Configuration
// writes are taken at any time and apply from the next timing update.
module morse_key_decoder_core
  import mkd_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mkd_key_if.sink    key_i,
  mkd_cfg_if.sink    cfg_i,
  mkd_evt_if.source  evt_o
);

  logic       smp_valid_q;
  logic       smp_key_q;
  logic       out_valid_q, out_valid_d;
  mkd_event_t out_q;
  logic       advance;
  logic       step;
  logic       evt_valid;
  mkd_event_t evt;
  mkd_cfg_t   cfg_q;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dash_threshold <= DashThresholdRst;
      cfg_q.letter_gap     <= LetterGapRst;
      cfg_q.word_gap       <= WordGapRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgDashThreshold: cfg_q.dash_threshold <= cfg_i.data;
        CfgLetterGap:     cfg_q.letter_gap     <= cfg_i.data;
        CfgWordGap:       cfg_q.word_gap       <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Pipeline control: the event stage moves when it is empty or drained
  assign advance     = !out_valid_q || evt_o.ready;
  assign key_i.ready = !smp_valid_q || advance;
  assign step        = smp_valid_q && advance;
  assign out_valid_d = advance ? evt_valid : out_valid_q;

  // Sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (key_i.ready) begin
      smp_valid_q <= key_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_i.valid && key_i.ready) begin
      smp_key_q <= key_i.key_down;
    end
  end

  mkd_timing #(
    .MaxElements (MaxElements)
  ) u_timing (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .key_down_i  (smp_key_q),
    .cfg_i       (cfg_q),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  // Event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && evt_valid) begin
      out_q <= evt;
    end
  end

  assign evt_o.valid          = out_valid_q;
  assign evt_o.event_kind     = out_q.kind;
  assign evt_o.letter_code    = out_q.letter;
  assign evt_o.symbol_length  = out_q.length;
  assign evt_o.symbol_pattern = out_q.pattern;

endmodule

// ===== rtl/core/mkd_letter_lut.sv =====
// ----------------------------------------------------------------------------
// mkd_letter_lut
// Maps a pending symbol (element count and dash pattern) to a letter code.
// ----------------------------------------------------------------------------
module mkd_letter_lut
  import mkd_pkg::*;
(
  input  logic [LengthWidth-1:0]  len_i,
  input  logic [PatternWidth-1:0] pattern_i,
  output logic [LetterWidth-1:0]  code_o
);

  logic found;

  // Compare against every table entry; codes are unique so the first hit wins
  always_comb begin
    found  = 1'b0;
    code_o = UnknownLetter;
    if (len_i <= MaxLookupLen) begin
      for (int i = 0; i < LetterCount; i++) begin
        if (!found && CodeLen[i] == len_i && CodeBits[i] == pattern_i) begin
          found  = 1'b1;
          code_o = LetterWidth'(i);
        end
      end
    end
  end

endmodule

// ===== rtl/core/mkd_timing.sv =====
// ----------------------------------------------------------------------------
// mkd_timing
// Press and gap timing, symbol assembly and event generation per key sample.
// ----------------------------------------------------------------------------
module mkd_timing
  import mkd_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       key_down_i,
  input  mkd_cfg_t   cfg_i,
  output logic       evt_valid_o,
  output mkd_event_t evt_o
);

  localparam int unsigned LenCapInt = (MaxElements > 15) ? 15 : MaxElements;
  localparam logic [LengthWidth-1:0] LenCap = LengthWidth'(LenCapInt);
  localparam logic [CountWidth-1:0]  SatMax = '1;

  logic                    key_held_q, key_held_d;
  logic [CountWidth-1:0]   press_q, press_d;
  logic [CountWidth-1:0]   idle_q, idle_d;
  logic [LengthWidth-1:0]  len_q, len_d;
  logic [PatternWidth-1:0] pat_q, pat_d;
  logic                    letter_done_q, letter_done_d;
  logic                    space_done_q, space_done_d;

  logic [CountWidth-1:0]   press_inc;
  logic [CountWidth-1:0]   idle_inc;
  logic                    is_dash;
  logic [LetterWidth-1:0]  letter_code;

  // Saturating increments and element classification
  assign press_inc = (press_q == SatMax) ? SatMax : press_q + 16'd1;
  assign idle_inc  = (idle_q == SatMax) ? SatMax : idle_q + 16'd1;
  assign is_dash   = (press_inc >= cfg_i.dash_threshold);

  mkd_letter_lut u_lut (
    .len_i     (len_q),
    .pattern_i (pat_q),
    .code_o    (letter_code)
  );

  // Advance the timing state for one sample and form its event
  always_comb begin
    key_held_d    = key_held_q;
    press_d       = press_q;
    idle_d        = idle_q;
    len_d         = len_q;
    pat_d         = pat_q;
    letter_done_d = letter_done_q;
    space_done_d  = space_done_q;
    evt_valid_o   = 1'b0;
    evt_o.kind    = EVT_DOT;
    evt_o.letter  = '0;

    if (step_i) begin
      if (key_down_i) begin
        if (!key_held_q) begin
          key_held_d    = 1'b1;
          press_d       = '0;
          letter_done_d = 1'b0;
          space_done_d  = 1'b0;
        end else begin
          press_d = press_inc;
        end
      end else if (key_held_q) begin
        // Release: append a dot or dash, dropping elements beyond the cap
        key_held_d = 1'b0;
        idle_d     = '0;
        if (len_q < LenCap) begin
          if (!len_q[LengthWidth-1]) begin
            pat_d[len_q[2:0]] = pat_q[len_q[2:0]] | is_dash;
          end
          len_d = len_q + 4'd1;
        end
        evt_valid_o = 1'b1;
        evt_o.kind  = is_dash ? EVT_DASH : EVT_DOT;
      end else begin
        idle_d = idle_inc;
        if (len_q != '0 && !letter_done_q && idle_inc > cfg_i.letter_gap) begin
          len_d         = '0;
          pat_d         = '0;
          letter_done_d = 1'b1;
          evt_valid_o   = 1'b1;
          evt_o.kind    = EVT_LETTER;
          evt_o.letter  = letter_code;
        end else if (letter_done_q && !space_done_q && idle_inc > cfg_i.word_gap) begin
          space_done_d = 1'b1;
          evt_valid_o  = 1'b1;
          evt_o.kind   = EVT_SPACE;
        end
      end
    end

    evt_o.length  = len_d;
    evt_o.pattern = pat_d;
  end

  // Hold the timing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_held_q    <= 1'b0;
      press_q       <= '0;
      idle_q        <= '0;
      len_q         <= '0;
      pat_q         <= '0;
      letter_done_q <= 1'b0;
      space_done_q  <= 1'b0;
    end else begin
      key_held_q    <= key_held_d;
      press_q       <= press_d;
      idle_q        <= idle_d;
      len_q         <= len_d;
      pat_q         <= pat_d;
      letter_done_q <= letter_done_d;
      space_done_q  <= space_done_d;
    end
  end

endmodule

// ===== rtl/core/mkd_checker.sv =====
// ----------------------------------------------------------------------------
// mkd_checker
// Port-level checks on the event channel of the Morse key decoder.
// ----------------------------------------------------------------------------
module mkd_checker
  import mkd_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    evt_valid_i,
  input logic                    evt_ready_i,
  input logic [1:0]              evt_kind_i,
  input logic [LetterWidth-1:0]  evt_letter_i,
  input logic [LengthWidth-1:0]  evt_length_i,
  input logic [PatternWidth-1:0] evt_pattern_i
);

  // A stalled event request holds its payload
  a_evt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_ready_i |=> evt_valid_i &&
      $stable(evt_kind_i) && $stable(evt_letter_i) &&
      $stable(evt_length_i) && $stable(evt_pattern_i))
    else $error("event payload changed while stalled");

  // Only letter events carry a letter code
  a_letter_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_kind_i != EVT_LETTER |-> evt_letter_i == '0)
    else $error("non-letter event with a letter code");

  // Letter codes stay within A to Z or unknown
  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i |-> evt_letter_i <= UnknownLetter)
    else $error("letter code out of range");

  // Letter and space events leave no pending symbol
  a_symbol_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && (evt_kind_i == EVT_LETTER || evt_kind_i == EVT_SPACE) |->
      evt_length_i == '0 && evt_pattern_i == '0)
    else $error("pending symbol not cleared after letter or space");

endmodule

bind morse_key_decoder_core mkd_checker u_mkd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .evt_valid_i   (evt_o.valid),
  .evt_ready_i   (evt_o.ready),
  .evt_kind_i    (evt_o.event_kind),
  .evt_letter_i  (evt_o.letter_code),
  .evt_length_i  (evt_o.symbol_length),
  .evt_pattern_i (evt_o.symbol_pattern)
);

// ===== sim/morse_key_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// morse_key_decoder_core_tb
// Self-checking bench for the Morse key decoder core.
// ----------------------------------------------------------------------------
// Key samples are sent one request at a time on the key channel. Each
// accepted sample steps a local decoder model that tracks press and gap
// timing and the pending symbol, and any event it gives is queued. Events
// leaving the core are popped in order and compared field by field.
//
// A directed table runs first: a dot under the reset threshold, the dash
// threshold edge, registers at zero and at full scale, gaps dropped with a
// symbol pending, symbol overflow, unknown symbols and letter/space on
// adjacent ticks. Random phases with short timing values follow, using
// well-formed symbols plus noise, with random stalls on the key channel, the
// event channel or both, and none in the final phase.
// ----------------------------------------------------------------------------
module morse_key_decoder_core_tb;
  import mkd_pkg::*;

  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LimitCycles  = 1_000_000;

  localparam logic [LengthWidth-1:0] LenCap =
    (MaxElementsDef > 15) ? 4'd15 : LengthWidth'(MaxElementsDef);
  localparam logic [CountWidth-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    ROW_KEYS,
    ROW_TYPED,
    ROW_TIMING
  } row_kind_e;

  // One directed row: reps of (press ticks down, gap ticks up), or a timing set
  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] press;
    logic [31:0] gap;
    logic [31:0] reps;
    mkd_cfg_t    cfg;
    mkd_event_t  want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  mkd_key_if key_if ();
  mkd_cfg_if cfg_if ();
  mkd_evt_if evt_if ();

  morse_key_decoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_if),
    .cfg_i  (cfg_if),
    .evt_o  (evt_if)
  );

  // Decoder model state
  mkd_cfg_t                cfg_now       = '{DashThresholdRst, LetterGapRst, WordGapRst};
  logic                    key_is_down   = 1'b0;
  logic [CountWidth-1:0]   press_count   = '0;
  logic [CountWidth-1:0]   idle_count    = '0;
  logic [LengthWidth-1:0]  sym_len       = '0;
  logic [PatternWidth-1:0] sym_pat       = '0;
  logic                    letter_sent   = 1'b0;
  logic                    space_sent    = 1'b0;

  mkd_event_t  due_events [$];

  logic        sink_ready  = 1'b0;
  int unsigned sink_stall  = 0;
  bit          sink_idle   = 1'b0;
  bit          src_idle    = 1'b0;

  int unsigned mismatches   = 0;
  int unsigned samples_sent = 0;
  int unsigned timing_sets  = 0;
  int unsigned n_dot        = 0;
  int unsigned n_dash       = 0;
  int unsigned n_letter     = 0;
  int unsigned n_unknown    = 0;
  int unsigned n_space      = 0;

  assign evt_if.ready = sink_ready;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Hard limit on run length
  initial begin
    #(ClkPeriod * LimitCycles);
    $display("timeout with %0d events still due", due_events.size());
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Look up a symbol in the A to Z table
  function automatic logic [LetterWidth-1:0] letter_for(input logic [LengthWidth-1:0] len,
                                                        input logic [PatternWidth-1:0] pat);
    if (len > MaxLookupLen) return UnknownLetter;
    for (int i = 0; i < LetterCount; i++) begin
      if (CodeLen[i] == len && CodeBits[i] == pat) return LetterWidth'(i);
    end
    return UnknownLetter;
  endfunction

  // Advance the decoder model by one key sample; returns 1 when it gives an event
  function automatic bit decode_sample(input logic down, output mkd_event_t ev);
    logic [CountWidth-1:0] dur;
    logic                  dash;
    ev = '0;
    if (down) begin
      if (!key_is_down) begin
        key_is_down = 1'b1;
        press_count = '0;
        letter_sent = 1'b0;
        space_sent  = 1'b0;
      end else if (press_count != CountMax) begin
        press_count = press_count + 16'd1;
      end
      return 1'b0;
    end
    // Release: classify the element and append it while there is room
    if (key_is_down) begin
      dur  = (press_count == CountMax) ? CountMax : press_count + 16'd1;
      dash = (dur >= cfg_now.dash_threshold);
      key_is_down = 1'b0;
      if (sym_len < LenCap) begin
        if (sym_len < 4'd8) sym_pat = sym_pat | (PatternWidth'(dash) << sym_len);
        sym_len = sym_len + 4'd1;
      end
      idle_count = '0;
      ev.kind    = dash ? EVT_DASH : EVT_DOT;
      ev.length  = sym_len;
      ev.pattern = sym_pat;
      return 1'b1;
    end
    if (idle_count != CountMax) idle_count = idle_count + 16'd1;
    // Letter gap passed: decode and clear the symbol
    if (sym_len != 0 && !letter_sent && idle_count > cfg_now.letter_gap) begin
      ev.kind     = EVT_LETTER;
      ev.letter   = letter_for(sym_len, sym_pat);
      sym_len     = '0;
      sym_pat     = '0;
      letter_sent = 1'b1;
      return 1'b1;
    end
    // Word gap passed after a letter: one space
    if (letter_sent && !space_sent && idle_count > cfg_now.word_gap) begin
      space_sent = 1'b1;
      ev.kind    = EVT_SPACE;
      ev.length  = sym_len;
      ev.pattern = sym_pat;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Send one key sample; a typed event replaces the model's one in the queue
  task automatic send_key(input logic down, input bit typed, input mkd_event_t typed_ev);
    mkd_event_t ev;
    if (src_idle && $urandom_range(0, 7) == 0) begin
      key_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    key_if.valid    <= 1'b1;
    key_if.key_down <= down;
    // Hold the request until the decoder takes it
    @(posedge clk_i);
    while (!key_if.ready) @(posedge clk_i);
    samples_sent++;
    if (decode_sample(down, ev)) due_events.push_back(typed ? typed_ev : ev);
  endtask

  // Press for press ticks, then release for gap ticks
  task automatic press_release(input int unsigned press, input int unsigned gap,
                               input bit typed, input mkd_event_t typed_ev);
    repeat (press) send_key(1'b1, typed, typed_ev);
    repeat (gap) send_key(1'b0, typed, typed_ev);
  endtask

  // Stop sending, wait for every due event, then let the pipeline settle
  task automatic wait_for_drain(input int unsigned extra);
    key_if.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // One register write request; valid stays high for a following write
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CountWidth-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic program_timing(input mkd_cfg_t c);
    write_reg(CfgDashThreshold, c.dash_threshold);
    write_reg(CfgLetterGap, c.letter_gap);
    write_reg(CfgWordGap, c.word_gap);
    cfg_if.valid <= 1'b0;
    cfg_now = c;
    timing_sets++;
  endtask

  function automatic stim_row_t keys(input int unsigned press, input int unsigned gap,
                                     input int unsigned reps);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_KEYS;
    r.press = press;
    r.gap   = gap;
    r.reps  = reps;
    return r;
  endfunction

  function automatic stim_row_t keys_typed(input int unsigned press, input int unsigned gap,
                                           input mkd_event_e kind,
                                           input logic [LetterWidth-1:0] letter,
                                           input logic [LengthWidth-1:0] len,
                                           input logic [PatternWidth-1:0] pat);
    stim_row_t r;
    r      = keys(press, gap, 1);
    r.kind = ROW_TYPED;
    r.want = '{kind, letter, len, pat};
    return r;
  endfunction

  function automatic stim_row_t timing(input logic [CountWidth-1:0] dt,
                                       input logic [CountWidth-1:0] lg,
                                       input logic [CountWidth-1:0] wg);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_TIMING;
    r.cfg  = '{dt, lg, wg};
    return r;
  endfunction

  task automatic run_row(input stim_row_t r);
    if (r.kind == ROW_TIMING) begin
      wait_for_drain(SettleCycles);
      program_timing(r.cfg);
    end else begin
      repeat (r.reps) press_release(r.press, r.gap, r.kind == ROW_TYPED, r.want);
    end
  endtask

  // Random phase: short timing values, mostly well-formed symbols
  task automatic random_phase(input int unsigned quota, input bit src_on, input bit sink_on,
                              input bit with_pause);
    mkd_cfg_t    c;
    int unsigned start;
    int unsigned elems;
    int unsigned gap;
    bit          paused;
    c.dash_threshold = CountWidth'($urandom_range(1, 4));
    c.letter_gap     = CountWidth'($urandom_range(1, 6));
    c.word_gap       = ($urandom_range(0, 1) == 1) ?
                       CountWidth'($urandom_range(1, c.letter_gap)) :
                       c.letter_gap + CountWidth'($urandom_range(1, 8));
    wait_for_drain(SettleCycles);
    program_timing(c);
    src_idle  = src_on;
    sink_idle = sink_on;
    paused    = !with_pause;
    start     = samples_sent;
    while (samples_sent - start < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        // Noise: a few random samples
        repeat ($urandom_range(1, 4)) send_key(1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        elems = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
        for (int e = 0; e < elems; e++) begin
          // Inner gaps stay short of the letter gap; the last one straddles both gaps
          gap = (e == elems - 1) ? $urandom_range(c.letter_gap, c.word_gap + 3) :
                                   $urandom_range(1, c.letter_gap);
          press_release($urandom_range(1, 2 * c.dash_threshold + 1), gap, 1'b0, '0);
          // Pause mid-symbol until the core has caught up
          if (!paused && samples_sent - start > quota / 2) begin
            wait_for_drain(1);
            paused = 1'b1;
          end
        end
      end
    end
  endtask

  // Event sink: check each accepted event, then drive ready with random stalls
  always @(posedge clk_i) begin : event_sink
    mkd_event_t want;
    if (rst_ni && evt_if.valid && sink_ready) begin
      case (evt_if.event_kind)
        EVT_DOT:    n_dot++;
        EVT_DASH:   n_dash++;
        EVT_LETTER: begin
          n_letter++;
          if (evt_if.letter_code == UnknownLetter) n_unknown++;
        end
        default:    n_space++;
      endcase
      if (due_events.size() == 0) begin
        report_mismatch("event with none due, kind", 32'(evt_if.event_kind), 0);
      end else begin
        want = due_events.pop_front();
        if (evt_if.event_kind !== want.kind)
          report_mismatch("event_kind", 32'(evt_if.event_kind), 32'(want.kind));
        if (evt_if.letter_code !== want.letter)
          report_mismatch("letter_code", 32'(evt_if.letter_code), 32'(want.letter));
        if (evt_if.symbol_length !== want.length)
          report_mismatch("symbol_length", 32'(evt_if.symbol_length), 32'(want.length));
        if (evt_if.symbol_pattern !== want.pattern)
          report_mismatch("symbol_pattern", 32'(evt_if.symbol_pattern), 32'(want.pattern));
      end
    end
    if (sink_stall != 0) begin
      sink_stall <= sink_stall - 1;
      sink_ready <= (sink_stall == 1);
    end else if (sink_idle && $urandom_range(0, 11) == 0) begin
      sink_stall <= $urandom_range(1, 17);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  initial begin : stimulus
    stim_row_t directed_rows [$];
    rst_ni          = 1'b0;
    key_if.valid    = 1'b0;
    key_if.key_down = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CfgDashThreshold;
    cfg_if.data     = '0;

    directed_rows = '{
      // Reset values: idle with nothing pending, shortest press is a dot
      keys(0, 3, 1),
      keys_typed(1, 1, EVT_DOT, 5'd0, 4'd1, 8'd0),
      // All registers at zero: every element a dash, gaps fire at once
      timing(16'd0, 16'd0, 16'd0),
      keys_typed(1, 1, EVT_DASH, 5'd0, 4'd2, 8'd2),
      keys_typed(0, 1, EVT_LETTER, 5'd0, 4'd0, 8'd0),
      keys_typed(0, 1, EVT_SPACE, 5'd0, 4'd0, 8'd0),
      keys(0, 4, 1),
      // Equal gaps: space one tick after the letter; long and overflowing symbols
      timing(16'd3, 16'd6, 16'd6),
      keys(1, 2, 5),
      keys(0, 8, 1),
      keys(3, 1, 9),
      keys(0, 8, 1),
      keys(3, 1, 4),
      keys_typed(0, 7, EVT_LETTER, UnknownLetter, 4'd0, 8'd0),
      keys_typed(0, 1, EVT_SPACE, 5'd0, 4'd0, 8'd0),
      // Word gap above letter gap: A, then S O S
      timing(16'd2, 16'd4, 16'd9),
      keys(1, 1, 1),
      keys(2, 1, 1),
      keys(0, 10, 1),
      keys(1, 1, 3),
      keys(0, 5, 1),
      keys(2, 1, 3),
      keys(0, 5, 1),
      keys(1, 1, 3),
      keys(0, 11, 1),
      // Press exactly at the threshold, then one tick short of it
      timing(16'd4, 16'd6, 16'd9),
      keys_typed(4, 1, EVT_DASH, 5'd0, 4'd1, 8'd1),
      keys(3, 8, 1),
      // Full-scale registers: a short press is a dot, no gap is passed
      timing(16'hFFFF, 16'hFFFF, 16'hFFFF),
      keys_typed(2, 1, EVT_DOT, 5'd0, 4'd1, 8'd0),
      keys(0, 5, 1),
      // Drop the gaps with a symbol pending: the idle count fires at once
      timing(16'd1, 16'd1, 16'd2),
      keys_typed(0, 1, EVT_LETTER, 5'd4, 4'd0, 8'd0),
      keys_typed(0, 1, EVT_SPACE, 5'd0, 4'd0, 8'd0),
      keys_typed(1, 1, EVT_DASH, 5'd0, 4'd1, 8'd1),
      keys(0, 3, 1)
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sink_idle = 1'b1;
    foreach (directed_rows[r]) run_row(directed_rows[r]);

    random_phase(45, 1'b1, 1'b1, 1'b0);
    random_phase(45, 1'b1, 1'b0, 1'b1);
    random_phase(45, 1'b0, 1'b1, 1'b0);
    random_phase(45, 1'b0, 1'b0, 1'b0);

    wait_for_drain(SettleCycles + 2);

    $display("%0d key samples over %0d timing settings", samples_sent, timing_sets);
    $display("events: %0d dots, %0d dashes, %0d letters (%0d unknown), %0d spaces",
             n_dot, n_dash, n_letter, n_unknown, n_space);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
